// File: rtl/utf8_to_utf16_decoder_assert.svh
// Assertion macros shared by the transcoder modules.
// Each expects clk and rst_n in scope.
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// Same-cycle implication.
`define U8U16_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define U8U16_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/u8u16_pkg.sv
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_BMP_MAX    = 21'h00FFFF;
    localparam logic [20:0] CP_SUPP_MIN   = 21'h010000;
    localparam logic [20:0] CP_3B_MIN     = 21'h000800;
    localparam logic [20:0] CP_2B_MIN     = 21'h000080;
    localparam logic [20:0] SURR_MIN      = 21'h00D800;
    localparam logic [20:0] SURR_MAX      = 21'h00DFFF;
    localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;

    localparam int QUEUE_DEPTH_DEF = 4;

    // What follows the replacement units of a job.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_UNIT,
        KIND_PAIR
    } unit_kind_t;

    // One queued job: rep replacement units, then an optional code point.
    typedef struct packed {
        logic [2:0]  rep;
        unit_kind_t  kind;
        logic [20:0] cp;
    } job_t;

endpackage

// File: rtl/u8u16_front.sv
module u8u16_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_text,
    output logic             push,
    output u8u16_pkg::job_t  job
);
    import u8u16_pkg::*;

    `include "utf8_to_utf16_decoder_assert.svh"

    logic [7:0]  lead_reg, lead_next;
    logic [2:0]  need_reg, need_next;
    logic [1:0]  got_reg, got_next;
    logic [5:0]  tail_reg [2];

    logic [2:0]  lead_need;
    logic        tl_ascii, tl_bad, tl_hold;
    logic        pend, is_cont, complete, ok, tail_we;
    logic [20:0] cp;

    // Classify the new byte as a lead.
    always_comb
    begin
        if (in_byte inside {[8'hC0:8'hDF]})
            lead_need = 3'd2;
        else if (in_byte inside {[8'hE0:8'hEF]})
            lead_need = 3'd3;
        else if (in_byte inside {[8'hF0:8'hF7]})
            lead_need = 3'd4;
        else
            lead_need = 3'd0;
    end

    assign tl_ascii = !in_byte[7];
    assign tl_bad   = !tl_ascii && (lead_need == 3'd0 || end_of_text);
    assign tl_hold  = (lead_need != 3'd0) && !end_of_text;

    assign pend     = (need_reg >= 3'd2) && (need_reg <= 3'd4) && (got_reg <= 2'd2);
    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign complete = (({1'b0, got_reg} + 3'd2) == need_reg);

    // Code point of a completed sequence and its validity.
    always_comb
    begin
        case (need_reg)
            3'd2:
            begin
                cp = {10'd0, lead_reg[4:0], in_byte[5:0]};
                ok = (cp >= CP_2B_MIN);
            end
            3'd3:
            begin
                cp = {5'd0, lead_reg[3:0], tail_reg[0], in_byte[5:0]};
                ok = (cp >= CP_3B_MIN) && ((cp < SURR_MIN) || (cp > SURR_MAX));
            end
            3'd4:
            begin
                cp = {lead_reg[2:0], tail_reg[0], tail_reg[1], in_byte[5:0]};
                ok = (cp >= CP_SUPP_MIN) && (cp <= CP_MAX);
            end
            default:
            begin
                cp = '0;
                ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        lead_next = lead_reg;
        need_next = need_reg;
        got_next  = got_reg;
        tail_we   = 1'b0;
        job.rep   = 3'd0;
        job.kind  = KIND_NONE;
        job.cp    = {13'd0, in_byte};

        if (!pend || !is_cont)
        begin
            // Pending sequence (if any) fails, then the byte is handled on its own: ASCII, new lead or bad byte.
            if (pend)
                job.rep = {1'b0, got_reg} + 3'd1;
            need_next = 3'd0;
            got_next  = 2'd0;
            if (tl_ascii)
                job.kind = KIND_UNIT;
            if (tl_bad)
                job.rep = job.rep + 3'd1;
            if (tl_hold)
            begin
                lead_next = in_byte;
                need_next = lead_need;
            end
        end
        else if (complete)
        begin
            need_next = 3'd0;
            got_next  = 2'd0;
            if (ok)
            begin
                job.cp   = cp;
                job.kind = (cp > CP_BMP_MAX) ? KIND_PAIR : KIND_UNIT;
            end
            else
            begin
                job.rep = {1'b0, got_reg} + 3'd2;
            end
        end
        else
        begin
            tail_we  = 1'b1;
            got_next = got_reg + 2'd1;
            if (end_of_text)
                job.rep = {1'b0, got_reg} + 3'd2;
        end

        if (end_of_text)
        begin
            need_next = 3'd0;
            got_next  = 2'd0;
        end
    end

    assign push = accept && ((job.rep != 3'd0) || (job.kind != KIND_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= '0;
            need_reg <= '0;
            got_reg  <= '0;
        end
        else if (accept)
        begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            got_reg  <= got_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && tail_we)
            tail_reg[got_reg[0]] <= in_byte[5:0];
    end

    `U8U16_ASSERT_NXT(a_end_flushes, accept && end_of_text, need_reg == 3'd0, "pending after end")
    `U8U16_ASSERT_IMP(a_got_bound, need_reg != 3'd0, ({1'b0, got_reg} + 3'd2) <= need_reg, "got overrun")

endmodule

// File: rtl/u8u16_queue.sv
module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u8u16_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output u8u16_pkg::job_t  head_job
);
    import u8u16_pkg::*;

    `include "utf8_to_utf16_decoder_assert.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    `U8U16_ASSERT_IMP(a_no_overflow, push, count_reg != CW'(DEPTH), "push into full queue")

endmodule

// File: rtl/u8u16_back.sv
module u8u16_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  u8u16_pkg::job_t  head_job,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [15:0] utf16_unit
    output logic             m_tlast    // run_last
);
    import u8u16_pkg::*;

    `include "utf8_to_utf16_decoder_assert.svh"

    logic        have_reg, have_next;
    logic [2:0]  rep_reg;
    unit_kind_t  kind_reg;
    logic [20:0] cp_reg;
    logic        lo_reg;
    logic        valid_reg;
    logic [15:0] data_reg;
    logic        last_reg;

    logic        out_load, emit, job_done;
    logic [15:0] unit;
    logic        unit_last;
    logic [20:0] v;

    assign out_load = !valid_reg || m_tready;
    assign emit     = out_load && have_reg;
    assign v        = cp_reg - CP_SUPP_MIN;

    // Next unit of the current job.
    always_comb
    begin
        if (rep_reg != 3'd0)
        begin
            unit      = REPLACEMENT;
            unit_last = (rep_reg == 3'd1) && (kind_reg == KIND_NONE);
        end
        else
        begin
            case (kind_reg)
                KIND_UNIT:
                begin
                    unit      = cp_reg[15:0];
                    unit_last = 1'b1;
                end
                KIND_PAIR:
                begin
                    unit      = lo_reg ? (LO_SURR_BASE | {6'd0, v[9:0]})
                                       : (HI_SURR_BASE | {6'd0, v[19:10]});
                    unit_last = lo_reg;
                end
                default:
                begin
                    unit      = REPLACEMENT;
                    unit_last = 1'b1;
                end
            endcase
        end
    end

    assign job_done  = emit && unit_last;
    assign pop       = head_valid && (!have_reg || job_done);
    assign have_next = pop ? 1'b1 : (job_done ? 1'b0 : have_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
            if (out_load)
                valid_reg <= have_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rep_reg  <= head_job.rep;
            kind_reg <= head_job.kind;
            cp_reg   <= head_job.cp;
            lo_reg   <= 1'b0;
        end
        else if (emit)
        begin
            if (rep_reg != 3'd0)
                rep_reg <= rep_reg - 3'd1;
            else if (kind_reg == KIND_PAIR)
                lo_reg <= 1'b1;
        end
        if (emit)
        begin
            data_reg <= unit;
            last_reg <= unit_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    `U8U16_ASSERT_IMP(a_job_nonempty, have_reg && kind_reg == KIND_NONE, rep_reg != 3'd0, "empty job")

endmodule

// File: rtl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 transcoder. One UTF-8 byte enters per word on the slave stream, with tlast on
// the final byte of the text; each byte gives zero to four UTF-16 units on the master stream, and
// tlast there marks the last unit of the byte that caused it. A byte is taken every cycle while
// the job queue (QUEUE_DEPTH entries) has room. The front decodes the byte at once and queues a
// job; the back sends its units one per cycle through an output register while the master stream
// accepts them. The first unit of a byte passes the queue slot, the back's job registers and the
// output register. Malformed input yields 0xFFFD per offending byte.
module utf8_to_utf16_decoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] utf16_unit
    output logic        m_tlast     // run_last
);
    import u8u16_pkg::*;

    logic  accept, push, full, pop, head_valid;
    job_t  job, head_job;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    u8u16_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_tdata),
        .end_of_text (s_tlast),
        .push        (push),
        .job         (job)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
